>>> rtl/core/plhm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package plhm_pkg;

  localparam int unsigned HIST_DEPTH = 16;
  localparam int unsigned MAX_RES    = 16;

  localparam int unsigned PTR_W  = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(HIST_DEPTH + 1);
  localparam int unsigned CNT_W  = $clog2(MAX_RES + 1);
  localparam int unsigned CMP_W  = (FILL_W > CNT_W) ? FILL_W : CNT_W;

  localparam logic [15:0] ELEV_RISE_RST = 16'd12288;
  localparam logic [15:0] ELEV_FALL_RST = 16'd11469;
  localparam logic [15:0] CRIT_RISE_RST = 16'd14746;
  localparam logic [15:0] CRIT_FALL_RST = 16'd13926;

  typedef enum logic [1:0] {
    LVL_NORMAL   = 2'd0,
    LVL_ELEVATED = 2'd1,
    LVL_CRITICAL = 2'd2
  } level_e;

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_REPORT = 2'd1,
    REQ_FORCE  = 2'd2,
    REQ_READ   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_ELEV_RISE = 2'd0,
    CFG_ELEV_FALL = 2'd1,
    CFG_CRIT_RISE = 2'd2,
    CFG_CRIT_FALL = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] utilisation;
    logic [2:0]  cause_domain;
    logic [1:0]  level_in;
    logic [4:0]  read_capacity;
  } plhm_in_t;

  typedef struct packed {
    logic [1:0]  level_now;
    logic        changed;
    logic [1:0]  rec_from;
    logic [1:0]  rec_to;
    logic [2:0]  rec_cause;
    logic [15:0] rec_utilisation;
    logic [31:0] rec_sequence;
    logic        rec_valid;
    logic        last;
  } plhm_out_t;

  typedef struct packed {
    logic [1:0]  from_lvl;
    logic [1:0]  to_lvl;
    logic [2:0]  cause;
    logic [15:0] util;
    logic [31:0] seq;
  } hist_rec_t;

  typedef struct packed {
    logic             wr_en;
    logic             rd_start;
    logic             rd_next;
    logic [CNT_W-1:0] rd_count;
  } hist_ctrl_t;

  typedef struct packed {
    logic [15:0] elev_rise;
    logic [15:0] elev_fall;
    logic [15:0] crit_rise;
    logic [15:0] crit_fall;
  } thresh_t;

  function automatic logic [1:0] clamp_level(input logic [1:0] v);
    return (v == 2'd3) ? LVL_CRITICAL : v;
  endfunction

  function automatic logic [1:0] next_level(input logic [1:0]  cur,
                                            input logic [15:0] u,
                                            input thresh_t     t);
    logic [1:0] nl;
    if (cur == LVL_CRITICAL) begin
      if (u >= t.crit_fall)      nl = LVL_CRITICAL;
      else if (u >= t.elev_fall) nl = LVL_ELEVATED;
      else                       nl = LVL_NORMAL;
    end else if (u >= t.crit_rise) begin
      nl = LVL_CRITICAL;
    end else if (cur == LVL_ELEVATED) begin
      nl = (u >= t.elev_fall) ? LVL_ELEVATED : LVL_NORMAL;
    end else begin
      nl = (u >= t.elev_rise) ? LVL_ELEVATED : LVL_NORMAL;
    end
    return nl;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/pressure_level_hysteresis_monitor.sv
`timescale 1ns / 1ps
`default_nettype none

// Three-level utilisation monitor with hysteresis. Each sample is classified
// as normal, elevated or critical against the rise/fall thresholds, floored
// by the last reported platform level; a level change (from a sample or a
// force) appends a sequenced transition record to a 16-entry history ring.
// Samples, reports and forces each give one result, registered at the
// accepting edge. A history read of n records reads the history RAM once
// ahead of the first record, then gives one record a cycle while the output
// is free; each RAM read lands in a read register, from which the output
// register takes it. An empty read gives a single invalid result. A new
// request is taken once the previous request's results are all out and the
// output register is free or being drained. The history RAM needs no clearing
// pass: only entries covered by the fill count are ever read.
module pressure_level_hysteresis_monitor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  plhm_pkg::plhm_in_t  in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output plhm_pkg::plhm_out_t out_res_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);
  import plhm_pkg::*;

  state_e            state_q, state_d;
  thresh_t           thresh_q, thresh_d;
  logic [1:0]        cur_q, cur_d;
  logic [1:0]        floor_q, floor_d;
  logic [31:0]       seq_q, seq_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  plhm_out_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;

  hist_ctrl_t        hist_ctrl;
  hist_rec_t         wr_rec, rd_rec;
  logic [FILL_W-1:0] fill;

  logic              in_fire, out_free;
  logic [1:0]        lvl_in, samp_lvl, new_lvl;
  logic              rec_en;
  logic [15:0]       rec_util;
  logic [CNT_W-1:0]  cap_c, count;
  logic [CMP_W-1:0]  fill_x;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE) || !out_free;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // decide whether this request records a transition
  always_comb begin
    lvl_in   = clamp_level(in_req_i.level_in);
    samp_lvl = next_level(cur_q, in_req_i.utilisation, thresh_q);
    if (floor_q > samp_lvl) begin
      samp_lvl = floor_q;
    end
    rec_en   = 1'b0;
    new_lvl  = cur_q;
    rec_util = '0;
    unique case (req_e'(in_req_i.req_type))
      REQ_SAMPLE: begin
        rec_en   = (samp_lvl != cur_q);
        new_lvl  = samp_lvl;
        rec_util = in_req_i.utilisation;
      end
      REQ_FORCE: begin
        rec_en  = (lvl_in != cur_q);
        new_lvl = lvl_in;
      end
      REQ_REPORT, REQ_READ: ;
      default: ;
    endcase
  end

  // records to return: min(fill, capacity, MAX_RES)
  always_comb begin
    cap_c  = (in_req_i.read_capacity > 5'(MAX_RES)) ? CNT_W'(MAX_RES)
                                                      : CNT_W'(in_req_i.read_capacity);
    fill_x = CMP_W'(fill);
    count  = (fill_x < CMP_W'(cap_c)) ? CNT_W'(fill_x) : cap_c;
  end

  always_comb begin
    wr_rec.from_lvl = cur_q;
    wr_rec.to_lvl   = new_lvl;
    wr_rec.cause    = in_req_i.cause_domain;
    wr_rec.util     = rec_util;
    wr_rec.seq      = seq_q + 32'd1;
  end

  always_comb begin
    thresh_d = thresh_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ELEV_RISE: thresh_d.elev_rise = cfg_data_i;
        CFG_ELEV_FALL: thresh_d.elev_fall = cfg_data_i;
        CFG_CRIT_RISE: thresh_d.crit_rise = cfg_data_i;
        CFG_CRIT_FALL: thresh_d.crit_fall = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    floor_d     = floor_q;
    seq_d       = seq_q;
    rem_d       = rem_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    hist_ctrl   = '0;
    hist_ctrl.rd_count = count;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          out_d      = '0;
          out_d.last = 1'b1;
          if (req_e'(in_req_i.req_type) == REQ_READ && count != '0) begin
            // read the oldest wanted record now, emit it from ST_READ once the output is free
            hist_ctrl.rd_start = 1'b1;
            rem_d   = count - 1'b1;
            state_d = ST_READ;
          end else begin
            out_valid_d = 1'b1;
            if (req_e'(in_req_i.req_type) == REQ_REPORT) begin
              floor_d = lvl_in;
            end
            if (rec_en) begin
              hist_ctrl.wr_en       = 1'b1;
              cur_d                 = new_lvl;
              seq_d                 = wr_rec.seq;
              out_d.changed         = 1'b1;
              out_d.rec_from        = wr_rec.from_lvl;
              out_d.rec_to          = wr_rec.to_lvl;
              out_d.rec_cause       = wr_rec.cause;
              out_d.rec_utilisation = wr_rec.util;
              out_d.rec_sequence    = wr_rec.seq;
              out_d.rec_valid       = 1'b1;
            end
            out_d.level_now = cur_d;
          end
        end
      end
      ST_READ: begin
        // read data holds until the output register takes it
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_d                 = '0;
          out_d.level_now       = cur_q;
          out_d.rec_from        = rd_rec.from_lvl;
          out_d.rec_to          = rd_rec.to_lvl;
          out_d.rec_cause       = rd_rec.cause;
          out_d.rec_utilisation = rd_rec.util;
          out_d.rec_sequence    = rd_rec.seq;
          out_d.rec_valid       = 1'b1;
          out_d.last            = (rem_q == '0);
          if (rem_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            hist_ctrl.rd_next = 1'b1;
            rem_d             = rem_q - 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= ST_IDLE;
      thresh_q.elev_rise <= ELEV_RISE_RST;
      thresh_q.elev_fall <= ELEV_FALL_RST;
      thresh_q.crit_rise <= CRIT_RISE_RST;
      thresh_q.crit_fall <= CRIT_FALL_RST;
      cur_q              <= LVL_NORMAL;
      floor_q            <= LVL_NORMAL;
      seq_q              <= '0;
      rem_q              <= '0;
      out_valid_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      thresh_q    <= thresh_d;
      cur_q       <= cur_d;
      floor_q     <= floor_d;
      seq_q       <= seq_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  plhm_hist u_hist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (hist_ctrl),
    .wr_rec_i (wr_rec),
    .rd_rec_o (rd_rec),
    .fill_o   (fill)
  );

`ifndef SYNTH
  a_changed_is_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.changed |-> out_res_o.rec_valid && out_res_o.last)
    else $error("transition result not a single valid record");

  a_mid_read_record : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_res_o.last |-> out_res_o.rec_valid && !out_res_o.changed)
    else $error("non-final result is not a history record");

  a_write_reported : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_ctrl.wr_en |=> out_valid_o && out_res_o.changed &&
                        out_res_o.rec_sequence == seq_q)
    else $error("history write without matching transition result");

  a_read_enters_burst : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_ctrl.rd_start |=> state_q == ST_READ)
    else $error("history read started without read burst");
`endif

endmodule

`default_nettype wire

>>> rtl/core/plhm_hist.sv
`timescale 1ns / 1ps
`default_nettype none

module plhm_hist (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  plhm_pkg::hist_ctrl_t          ctrl_i,
  input  plhm_pkg::hist_rec_t           wr_rec_i,
  output plhm_pkg::hist_rec_t           rd_rec_o,
  output logic [plhm_pkg::FILL_W-1:0]   fill_o
);
  import plhm_pkg::*;

  hist_rec_t        mem_q [HIST_DEPTH];
  hist_rec_t        rd_rec_q;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_addr_q, rd_addr_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [PTR_W:0]   wr_ptr_x, cnt_x, diff_x;
  logic             rd_en;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(HIST_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // first entry of a read: write pointer minus count, modulo the depth
  always_comb begin
    wr_ptr_x = {1'b0, wr_ptr_q};
    cnt_x    = (PTR_W + 1)'(ctrl_i.rd_count);
    diff_x   = wr_ptr_x - cnt_x;
    if (wr_ptr_x < cnt_x) begin
      diff_x = diff_x + (PTR_W + 1)'(HIST_DEPTH);
    end
  end

  always_comb begin
    rd_en     = ctrl_i.rd_start || ctrl_i.rd_next;
    rd_addr_d = rd_addr_q;
    if (ctrl_i.rd_start) begin
      rd_addr_d = diff_x[PTR_W-1:0];
    end else if (ctrl_i.rd_next) begin
      rd_addr_d = ptr_inc(rd_addr_q);
    end
    wr_ptr_d = wr_ptr_q;
    fill_d   = fill_q;
    if (ctrl_i.wr_en) begin
      wr_ptr_d = ptr_inc(wr_ptr_q);
      if (fill_q != FILL_W'(HIST_DEPTH)) begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_addr_q <= '0;
      fill_q    <= '0;
    end else begin
      wr_ptr_q  <= wr_ptr_d;
      rd_addr_q <= rd_addr_d;
      fill_q    <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[wr_ptr_q] <= wr_rec_i;
    end
    if (rd_en) begin
      rd_rec_q <= mem_q[rd_addr_d];
    end
  end

  assign rd_rec_o = rd_rec_q;
  assign fill_o   = fill_q;

`ifndef SYNTH
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(HIST_DEPTH))
    else $error("history fill count beyond depth");

  a_no_rw_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.wr_en |-> !(ctrl_i.rd_start || ctrl_i.rd_next))
    else $error("history write overlaps a read");

  a_read_in_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.rd_start |-> (ctrl_i.rd_count != '0) &&
                        (CMP_W'(ctrl_i.rd_count) <= CMP_W'(fill_q)))
    else $error("history read of more records than stored");
`endif

endmodule

`default_nettype wire

>>> bench/pressure_level_hysteresis_monitor_tb.sv
`timescale 1ns / 1ps

module pressure_level_hysteresis_monitor_tb;
  import plhm_pkg::*;

  localparam logic [1:0] LVL_CODE_THREE = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned IN_W = $bits(plhm_in_t);

  logic      clk;
  logic      rst_ni;
  logic      in_valid;
  logic      in_stall;
  plhm_in_t  in_req;
  logic      out_valid;
  logic      out_stall;
  plhm_out_t out_res;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // Monitor state as the bench sees it
  thresh_t     thr = '{elev_rise: ELEV_RISE_RST, elev_fall: ELEV_FALL_RST,
                       crit_rise: CRIT_RISE_RST, crit_fall: CRIT_FALL_RST};
  logic [1:0]  cur_lvl = LVL_NORMAL;
  logic [1:0]  floor_lvl = LVL_NORMAL;
  logic [31:0] trans_seq = '0;
  int unsigned ring_wptr = 0;
  int unsigned ring_fill = 0;
  hist_rec_t   ring [HIST_DEPTH];

  plhm_out_t outcomes_due[$];
  plhm_out_t want_res;
  int        error_count = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  int        hold_cycles = 0;

  pressure_level_hysteresis_monitor DUT (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_res_o   (out_res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [1:0] sat_level(input logic [1:0] code);
    return (code > LVL_CRITICAL) ? LVL_CRITICAL : code;
  endfunction

  function automatic logic [1:0] classify(input logic [1:0] cur, input logic [15:0] u);
    if (cur == LVL_CRITICAL) begin
      if (u >= thr.crit_fall) return LVL_CRITICAL;
      return (u >= thr.elev_fall) ? LVL_ELEVATED : LVL_NORMAL;
    end
    if (u >= thr.crit_rise) return LVL_CRITICAL;
    if (cur == LVL_ELEVATED) return (u >= thr.elev_fall) ? LVL_ELEVATED : LVL_NORMAL;
    return (u >= thr.elev_rise) ? LVL_ELEVATED : LVL_NORMAL;
  endfunction

  function automatic plhm_out_t show_record(input hist_rec_t rec);
    plhm_out_t res;
    res = '0;
    res.level_now       = cur_lvl;
    res.rec_from        = rec.from_lvl;
    res.rec_to          = rec.to_lvl;
    res.rec_cause       = rec.cause;
    res.rec_utilisation = rec.util;
    res.rec_sequence    = rec.seq;
    res.rec_valid       = 1'b1;
    return res;
  endfunction

  function automatic void compute_outcome(input plhm_in_t req);
    plhm_out_t   res;
    hist_rec_t   rec;
    logic [1:0]  target;
    logic [15:0] rec_util;
    logic        log_it;
    int unsigned cnt;
    int unsigned first;
    log_it = 1'b0;
    target = cur_lvl;
    rec_util = '0;
    case (req.req_type)
      REQ_SAMPLE: begin
        target = classify(cur_lvl, req.utilisation);
        if (floor_lvl > target) target = floor_lvl;
        rec_util = req.utilisation;
        log_it = (target != cur_lvl);
      end
      REQ_REPORT: floor_lvl = sat_level(req.level_in);
      REQ_FORCE: begin
        target = sat_level(req.level_in);
        log_it = (target != cur_lvl);
      end
      REQ_READ: begin
        cnt = ring_fill;
        if (req.read_capacity < cnt) cnt = req.read_capacity;
        if (cnt > MAX_RES) cnt = MAX_RES;
        if (cnt == 0) begin
          res = '0;
          res.level_now = cur_lvl;
          res.last = 1'b1;
          outcomes_due.push_back(res);
        end else begin
          // newest cnt records, oldest of them first
          first = (ring_wptr + HIST_DEPTH - cnt) % HIST_DEPTH;
          for (int k = 0; k < cnt; k++) begin
            res = show_record(ring[(first + k) % HIST_DEPTH]);
            res.last = (k + 1 == cnt);
            outcomes_due.push_back(res);
          end
        end
      end
    endcase
    if (req.req_type != REQ_READ) begin
      res = '0;
      if (log_it) begin
        trans_seq++;
        rec = '{from_lvl: cur_lvl, to_lvl: target, cause: req.cause_domain,
                util: rec_util, seq: trans_seq};
        ring[ring_wptr] = rec;
        ring_wptr = (ring_wptr + 1) % HIST_DEPTH;
        if (ring_fill < HIST_DEPTH) ring_fill++;
        cur_lvl = target;
        res = show_record(rec);
        res.changed = 1'b1;
      end
      res.level_now = cur_lvl;
      res.last = 1'b1;
      outcomes_due.push_back(res);
    end
  endfunction

  function automatic bit result_matches(input plhm_out_t w, input plhm_out_t g);
    return g.level_now === w.level_now && g.changed === w.changed &&
           g.rec_from === w.rec_from && g.rec_to === w.rec_to &&
           g.rec_cause === w.rec_cause && g.rec_utilisation === w.rec_utilisation &&
           g.rec_sequence === w.rec_sequence && g.rec_valid === w.rec_valid &&
           g.last === w.last;
  endfunction

  task automatic note_mismatch(input string what, input plhm_out_t w, input plhm_out_t g);
    error_count++;
    if (error_count <= 10) begin
      $display("[%0t] %s", $realtime, what);
      $display("  expected lvl=%0d chg=%0b from=%0d to=%0d cause=%0d util=%h seq=%0d vld=%0b last=%0b",
               w.level_now, w.changed, w.rec_from, w.rec_to, w.rec_cause,
               w.rec_utilisation, w.rec_sequence, w.rec_valid, w.last);
      $display("  actual   lvl=%0d chg=%0b from=%0d to=%0d cause=%0d util=%h seq=%0d vld=%0b last=%0b",
               g.level_now, g.changed, g.rec_from, g.rec_to, g.rec_cause,
               g.rec_utilisation, g.rec_sequence, g.rec_valid, g.last);
    end
  endtask

  // Predict on each accepted request, then check each accepted result
  always @(posedge clk) begin
    if (rst_ni && in_valid && !in_stall) compute_outcome(in_req);
    if (rst_ni && out_valid && !out_stall) begin
      if (outcomes_due.size() == 0) begin
        note_mismatch("result with nothing due", '0, out_res);
      end else begin
        want_res = outcomes_due.pop_front();
        if (!result_matches(want_res, out_res)) note_mismatch("result mismatch", want_res, out_res);
      end
    end
  end

  // Result side: long hold-off first, else random stall
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
  endtask

  // Enter and leave at a falling edge; valid stays high for a following request
  task automatic send_request(input plhm_in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic settle_outputs();
    in_valid <= 1'b0;
    while (outcomes_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_thresholds(input thresh_t t);
    cfg_idx_e    order [4];
    logic [15:0] vals [4];
    order = '{CFG_ELEV_RISE, CFG_ELEV_FALL, CFG_CRIT_RISE, CFG_CRIT_FALL};
    vals = '{t.elev_rise, t.elev_fall, t.crit_rise, t.crit_fall};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= order[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    thr = t;
  endtask

  function automatic plhm_in_t make_req(input req_e kind, input logic [15:0] util,
                                        input logic [2:0] cause, input logic [1:0] lvl,
                                        input logic [4:0] cap);
    plhm_in_t r;
    r.req_type = kind;
    r.utilisation = util;
    r.cause_domain = cause;
    r.level_in = lvl;
    r.read_capacity = cap;
    return r;
  endfunction

  function automatic logic [15:0] pick_util();
    logic [15:0] base;
    case ($urandom_range(3))
      0: return 16'($urandom_range(16'hFFFF));
      3: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: begin
        case ($urandom_range(3))
          0: base = thr.elev_rise;
          1: base = thr.elev_fall;
          2: base = thr.crit_rise;
          default: base = thr.crit_fall;
        endcase
        // land on, just under or just over a threshold
        return base + 16'($urandom_range(4)) - 16'd2;
      end
    endcase
  endfunction

  function automatic plhm_in_t random_request();
    plhm_in_t    r;
    int unsigned pick;
    r = plhm_in_t'(IN_W'({$urandom, $urandom}));
    pick = $urandom_range(99);
    if (pick < 50) begin
      r.req_type = REQ_SAMPLE;
      r.utilisation = pick_util();
    end else if (pick < 65) begin
      r.req_type = REQ_FORCE;
    end else if (pick < 75) begin
      // keep the floor mostly low so samples still move the level
      r.req_type = REQ_REPORT;
      if ($urandom_range(2) != 0) r.level_in = LVL_NORMAL;
    end else begin
      r.req_type = REQ_READ;
      r.read_capacity = ($urandom_range(4) == 0) ? 5'($urandom_range(31))
                                                  : 5'($urandom_range(16));
    end
    return r;
  endfunction

  task automatic run_random_requests(input int n);
    repeat (n) send_request(random_request());
  endtask

  task automatic test_reset_thresholds();
    set_idling(31, 75);
    send_request(make_req(REQ_READ, 16'h0000, 3'd0, LVL_NORMAL, 5'd16));
    send_request(make_req(REQ_READ, 16'hFFFF, 3'd7, LVL_CODE_THREE, 5'd0));
    send_request(make_req(REQ_SAMPLE, 16'd0, 3'd0, LVL_NORMAL, 5'd0));
    send_request(make_req(REQ_SAMPLE, 16'd12287, 3'd2, LVL_NORMAL, 5'd0));
    send_request(make_req(REQ_SAMPLE, 16'd12288, 3'd1, LVL_NORMAL, 5'd0));
    send_request(make_req(REQ_SAMPLE, 16'd11469, 3'd1, LVL_NORMAL, 5'd0));
    send_request(make_req(REQ_SAMPLE, 16'd14746, 3'd7, LVL_NORMAL, 5'd0));
    send_request(make_req(REQ_SAMPLE, 16'd13926, 3'd4, LVL_NORMAL, 5'd0));
    send_request(make_req(REQ_SAMPLE, 16'd13925, 3'd4, LVL_NORMAL, 5'd0));
    send_request(make_req(REQ_SAMPLE, 16'd11468, 3'd2, LVL_NORMAL, 5'd0));
    send_request(make_req(REQ_SAMPLE, 16'hFFFF, 3'd5, LVL_NORMAL, 5'd0));
    send_request(make_req(REQ_FORCE, 16'h1234, 3'd6, LVL_CRITICAL, 5'd0));
    send_request(make_req(REQ_FORCE, 16'hFFFF, 3'd6, LVL_NORMAL, 5'd0));
    send_request(make_req(REQ_FORCE, 16'h0000, 3'd3, LVL_CODE_THREE, 5'd0));
    send_request(make_req(REQ_FORCE, 16'h0000, 3'd0, LVL_ELEVATED, 5'd0));
    send_request(make_req(REQ_REPORT, 16'h0000, 3'd0, LVL_CODE_THREE, 5'd0));
    send_request(make_req(REQ_SAMPLE, 16'd0, 3'd1, LVL_NORMAL, 5'd0));
    send_request(make_req(REQ_REPORT, 16'h0000, 3'd0, LVL_NORMAL, 5'd0));
    send_request(make_req(REQ_SAMPLE, 16'd0, 3'd2, LVL_NORMAL, 5'd0));
    send_request(make_req(REQ_REPORT, 16'h0000, 3'd0, LVL_ELEVATED, 5'd0));
    send_request(make_req(REQ_SAMPLE, 16'd0, 3'd3, LVL_NORMAL, 5'd0));
    send_request(make_req(REQ_REPORT, 16'h0000, 3'd0, LVL_NORMAL, 5'd0));
    send_request(make_req(REQ_READ, 16'h0000, 3'd0, LVL_NORMAL, 5'd31));
    send_request(make_req(REQ_READ, 16'h0000, 3'd0, LVL_NORMAL, 5'd3));
  endtask

  task automatic test_threshold_extremes();
    thresh_t t;
    settle_outputs();
    t = '{elev_rise: 16'h0000, elev_fall: 16'h0000, crit_rise: 16'h0000, crit_fall: 16'h0000};
    write_thresholds(t);
    send_request(make_req(REQ_SAMPLE, 16'h0000, 3'd1, LVL_NORMAL, 5'd0));
    send_request(make_req(REQ_SAMPLE, 16'hFFFF, 3'd1, LVL_NORMAL, 5'd0));
    send_request(make_req(REQ_FORCE, 16'h0000, 3'd2, LVL_NORMAL, 5'd0));
    send_request(make_req(REQ_SAMPLE, 16'h0000, 3'd3, LVL_NORMAL, 5'd0));
    send_request(make_req(REQ_READ, 16'h0000, 3'd0, LVL_NORMAL, 5'd4));
    settle_outputs();
    t = '{elev_rise: 16'hFFFF, elev_fall: 16'hFFFF, crit_rise: 16'hFFFF, crit_fall: 16'hFFFF};
    write_thresholds(t);
    send_request(make_req(REQ_SAMPLE, 16'hFFFE, 3'd4, LVL_NORMAL, 5'd0));
    send_request(make_req(REQ_SAMPLE, 16'hFFFF, 3'd5, LVL_NORMAL, 5'd0));
    send_request(make_req(REQ_SAMPLE, 16'hFFFE, 3'd6, LVL_NORMAL, 5'd0));
    send_request(make_req(REQ_SAMPLE, 16'hFFFE, 3'd6, LVL_NORMAL, 5'd0));
    settle_outputs();
    // fall above rise on both levels
    t = '{elev_rise: 16'd1000, elev_fall: 16'd3000, crit_rise: 16'd5000, crit_fall: 16'd8000};
    write_thresholds(t);
    send_request(make_req(REQ_SAMPLE, 16'd2000, 3'd7, LVL_NORMAL, 5'd0));
    send_request(make_req(REQ_SAMPLE, 16'd2000, 3'd7, LVL_NORMAL, 5'd0));
    send_request(make_req(REQ_SAMPLE, 16'd6000, 3'd0, LVL_NORMAL, 5'd0));
    send_request(make_req(REQ_SAMPLE, 16'd6000, 3'd0, LVL_NORMAL, 5'd0));
    send_request(make_req(REQ_READ, 16'h0000, 3'd0, LVL_NORMAL, 5'd8));
  endtask

  task automatic test_random_traffic();
    thresh_t     t;
    int unsigned v[$];
    repeat (4) v.push_back($urandom_range(16'hFFFF));
    v.sort();
    t = '{elev_fall: 16'(v[0]), elev_rise: 16'(v[1]),
          crit_fall: 16'(v[2]), crit_rise: 16'(v[3])};
    settle_outputs();
    write_thresholds(t);
    set_idling(31, 75);
    run_random_requests(60);
    settle_outputs();
    write_thresholds(thresh_t'({$urandom, $urandom}));
    set_idling(75, 31);
    run_random_requests(60);
    settle_outputs();
    t = '{elev_rise: ELEV_RISE_RST, elev_fall: ELEV_FALL_RST,
          crit_rise: CRIT_RISE_RST, crit_fall: CRIT_FALL_RST};
    write_thresholds(t);
    set_idling(0, 0);
    run_random_requests(62);
  endtask

  task automatic test_output_hold_off();
    settle_outputs();
    set_idling(0, 0);
    hold_cycles = 80;
    send_request(make_req(REQ_READ, 16'h0000, 3'd0, LVL_NORMAL, 5'd16));
    run_random_requests(23);
    // pause the request side until every result is back
    settle_outputs();
    set_idling(31, 0);
    hold_cycles = 40;
    run_random_requests(16);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ELEV_RISE;
    cfg_data = '0;
    repeat (3) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);
    test_reset_thresholds();
    test_threshold_extremes();
    test_random_traffic();
    test_output_hold_off();
    settle_outputs();
    repeat (20) @(negedge clk);
    if (error_count == 0 && outcomes_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/plhm_pkg.sv
rtl/core/plhm_hist.sv
rtl/core/pressure_level_hysteresis_monitor.sv
bench/pressure_level_hysteresis_monitor_tb.sv
